FILE: design/tpa_pkg.sv
// Package with types, constants and helpers for the triangle primitive assembly block.
package tpa_pkg;

  // Vertex index width kept in state; wider input bits are ignored
  localparam int INDEX_WIDTH = 32;
  localparam int IN_WIDTH    = 32;
  localparam int BASE_WIDTH  = 32;
  localparam int VERT_WIDTH  = 33;
  localparam int COUNT_WIDTH = 32;
  localparam int MAXI_WIDTH  = 32;
  localparam int PAD_WIDTH   = 5;
  localparam int OUT_WIDTH   = 3 * VERT_WIDTH + COUNT_WIDTH + MAXI_WIDTH + PAD_WIDTH;

  // Configuration port
  localparam int CFG_IDX_WIDTH  = 2;
  localparam int CFG_DATA_WIDTH = 32;
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_MODE = 2'd0;
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_BASE = 2'd1;

  // Topology codes
  typedef enum logic [1:0] {
    MODE_LIST  = 2'd0,
    MODE_FAN   = 2'd1,
    MODE_STRIP = 2'd2,
    MODE_NONE  = 2'd3
  } mode_t;

  // Phase of the index sequence: two corners collected, then even/odd triangle
  typedef enum logic [1:0] {
    PH_FIRST  = 2'd0,
    PH_SECOND = 2'd1,
    PH_EVEN   = 2'd2,
    PH_ODD    = 2'd3
  } phase_t;

  typedef logic [INDEX_WIDTH-1:0] idx_t;

  // Result payload, last field in the lowest bits
  typedef struct packed {
    logic [PAD_WIDTH-1:0]   pad;
    logic [MAXI_WIDTH-1:0]  max_index;
    logic [COUNT_WIDTH-1:0] triangle_count;
    logic [VERT_WIDTH-1:0]  vert_c;
    logic [VERT_WIDTH-1:0]  vert_b;
    logic [VERT_WIDTH-1:0]  vert_a;
  } out_payload_t;

  // Largest of three corners
  function automatic idx_t max3(input idx_t a, input idx_t b, input idx_t c);
    idx_t m;
    m = a;
    if (b > m) m = b;
    if (c > m) m = c;
    return m;
  endfunction

endpackage

FILE: design/triangle_primitive_assembly.sv
// Triangle primitive assembly: index stream in, triangles (list, fan, strip) out.
// A triangle is loaded into the output register when the index that closes it is accepted.
// Throughput: one index per cycle while in_tready is high; the state update and result compute are combinational.
// An index is taken whenever the output register is empty or being drained.
// Reset (rst_n low, synchronous) clears mode, base, primitive state and the output valid.
// An index marked tlast is processed and then clears the primitive state.
module triangle_primitive_assembly (
  input  logic                                    clk,
  input  logic                                    rst_n,
  // in_tdata: index[31:0]; in_tlast: last
  input  logic                                    in_tvalid,
  output logic                                    in_tready,
  input  logic [tpa_pkg::IN_WIDTH-1:0]            in_tdata,
  input  logic                                    in_tlast,
  // out_tdata: vert_a[32:0], vert_b[65:33], vert_c[98:66], triangle_count[130:99],
  //            max_index[162:131], zero pad[167:163]
  output logic                                    out_tvalid,
  input  logic                                    out_tready,
  output logic [tpa_pkg::OUT_WIDTH-1:0]           out_tdata,
  // Configuration write channel
  input  logic                                    cfg_valid,
  output logic                                    cfg_ready,
  input  logic [tpa_pkg::CFG_IDX_WIDTH-1:0]       cfg_index,
  input  logic [tpa_pkg::CFG_DATA_WIDTH-1:0]      cfg_data
);
  import tpa_pkg::*;

  mode_t                  mode_r;
  logic [BASE_WIDTH-1:0]  base_r;
  idx_t                   anchor_r, anchor_nxt;
  idx_t                   older_r, older_nxt;
  idx_t                   newer_r, newer_nxt;
  phase_t                 phase_r, phase_nxt;
  logic [COUNT_WIDTH-1:0] total_r, total_nxt;
  idx_t                   largest_r, largest_nxt;
  logic                   out_valid_r;
  out_payload_t           out_r, out_nxt;

  logic                   in_acc;
  logic                   emit;
  idx_t                   cur, anchor_use, ca, cb, cc, corner_max;

  assign cfg_ready  = 1'b1;
  assign in_tready  = !out_valid_r || out_tready;
  assign in_acc     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_r;
  assign cur        = in_tdata[INDEX_WIDTH-1:0];

  // Assemble the triangle and advance the phase
  always_comb begin
    emit       = 1'b0;
    anchor_use = (phase_r == PH_FIRST) ? cur : anchor_r;
    ca         = older_r;
    cb         = newer_r;
    cc         = cur;
    anchor_nxt = anchor_r;
    older_nxt  = older_r;
    newer_nxt  = newer_r;
    phase_nxt  = phase_r;
    unique case (mode_r)
      MODE_LIST: begin
        if (phase_r == PH_EVEN || phase_r == PH_ODD) begin
          emit      = 1'b1;
          phase_nxt = PH_FIRST;
        end else begin
          phase_nxt = phase_t'(phase_r + 2'd1);
        end
      end
      MODE_FAN, MODE_STRIP: begin
        if (phase_r == PH_EVEN || phase_r == PH_ODD) begin
          emit      = 1'b1;
          phase_nxt = (phase_r == PH_EVEN) ? PH_ODD : PH_EVEN;
          if (mode_r == MODE_FAN) begin
            ca = anchor_use;
          end else if (phase_r == PH_ODD) begin
            ca = newer_r;
            cb = older_r;
          end
        end else begin
          phase_nxt = phase_t'(phase_r + 2'd1);
        end
      end
      MODE_NONE: begin
        emit = 1'b0;
      end
    endcase
    if (mode_r != MODE_NONE) begin
      anchor_nxt = anchor_use;
      older_nxt  = newer_r;
      newer_nxt  = cur;
    end
  end

  // Update the running count and maximum, build the result
  always_comb begin
    corner_max  = max3(ca, cb, cc);
    total_nxt   = total_r;
    largest_nxt = largest_r;
    if (emit) begin
      if (total_r != {COUNT_WIDTH{1'b1}}) total_nxt = total_r + 1'b1;
      if (corner_max > largest_r) largest_nxt = corner_max;
    end
    out_nxt.pad            = '0;
    out_nxt.vert_a         = {1'b0, base_r} + {{(VERT_WIDTH-INDEX_WIDTH){1'b0}}, ca};
    out_nxt.vert_b         = {1'b0, base_r} + {{(VERT_WIDTH-INDEX_WIDTH){1'b0}}, cb};
    out_nxt.vert_c         = {1'b0, base_r} + {{(VERT_WIDTH-INDEX_WIDTH){1'b0}}, cc};
    out_nxt.triangle_count = total_nxt;
    out_nxt.max_index      = MAXI_WIDTH'(largest_nxt);
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_LIST;
      base_r <= '0;
    end else if (cfg_valid) begin
      if (cfg_index == CFG_MODE) mode_r <= mode_t'(cfg_data[1:0]);
      else if (cfg_index == CFG_BASE) base_r <= cfg_data[BASE_WIDTH-1:0];
    end
  end

  // Primitive state; clear after the last index
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      anchor_r  <= '0;
      older_r   <= '0;
      newer_r   <= '0;
      phase_r   <= PH_FIRST;
      total_r   <= '0;
      largest_r <= '0;
    end else if (in_acc) begin
      if (in_tlast) begin
        anchor_r  <= '0;
        older_r   <= '0;
        newer_r   <= '0;
        phase_r   <= PH_FIRST;
        total_r   <= '0;
        largest_r <= '0;
      end else begin
        anchor_r  <= anchor_nxt;
        older_r   <= older_nxt;
        newer_r   <= newer_nxt;
        phase_r   <= phase_nxt;
        total_r   <= total_nxt;
        largest_r <= largest_nxt;
      end
    end
  end

  // Output register: load on an emitting request, drop when taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc) begin
      out_valid_r <= emit;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && emit) out_r <= out_nxt;
  end

`ifndef SYNTHESIS
  // A new result only follows an accepted request
  a_out_from_req: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(in_acc))
    else $error("result appeared without an accepted request");

  // Last index clears the primitive state
  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_tlast |=> phase_r == PH_FIRST && total_r == '0 && largest_r == '0)
    else $error("state not cleared after last index");

  // Every shown triangle counts at least itself
  a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_r.triangle_count != '0)
    else $error("triangle count is zero on a valid result");
`endif

endmodule

FILE: sim/tpa_checker.sv
// Checker for the triangle primitive assembly: watches all channels, predicts and compares.
module tpa_checker
  import tpa_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  input  logic                      in_tready,
  input  logic [IN_WIDTH-1:0]       in_tdata,
  input  logic                      in_tlast,
  input  logic                      out_tvalid,
  input  logic                      out_tready,
  input  logic [OUT_WIDTH-1:0]      out_tdata,
  input  logic                      cfg_valid,
  input  logic                      cfg_ready,
  input  logic [CFG_IDX_WIDTH-1:0]  cfg_index,
  input  logic [CFG_DATA_WIDTH-1:0] cfg_data,
  output int                        fail_count,
  output int                        pending
);
  timeunit 1ns;
  timeprecision 1ps;

  // Shadow of the configuration registers
  mode_t                topo;
  logic [BASE_WIDTH-1:0] base;

  // Shadow of the primitive state
  idx_t                 anchor;
  idx_t                 corner_old;
  idx_t                 corner_new;
  phase_t               phase;
  logic [COUNT_WIDTH-1:0] tri_total;
  idx_t                 peak;

  out_payload_t         tri_expected[$];
  int                   mismatches = 0;

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  task automatic note_mismatch(input string what, input logic [63:0] got,
                               input logic [63:0] want);
    $display("[%0t] triangle mismatch on %s: got %h, want %h", $time, what, got, want);
    mismatches++;
  endtask

  task automatic clear_primitive();
    anchor     = '0;
    corner_old = '0;
    corner_new = '0;
    phase      = PH_FIRST;
    tri_total  = '0;
    peak       = '0;
  endtask

  // Advance the shadow state by one accepted index request
  task automatic assemble(input idx_t cur, input logic is_last);
    logic         emit;
    idx_t         a, b, c, m;
    out_payload_t tri_item;
    emit = 1'b0;
    a = '0;
    b = '0;
    c = '0;
    if (topo != MODE_NONE) begin
      if (phase == PH_FIRST) anchor = cur;
      if (phase == PH_EVEN || phase == PH_ODD) begin
        emit = 1'b1;
        c    = cur;
        if (topo == MODE_LIST) begin
          a = corner_old;
          b = corner_new;
          phase = PH_FIRST;
        end else begin
          if (topo == MODE_FAN) begin
            a = anchor;
            b = corner_new;
          end else if (phase == PH_EVEN) begin
            a = corner_old;
            b = corner_new;
          end else begin
            // odd strip triangle flips the winding
            a = corner_new;
            b = corner_old;
          end
          phase = (phase == PH_EVEN) ? PH_ODD : PH_EVEN;
        end
      end else begin
        phase = phase_t'(phase + 2'd1);
      end
      corner_old = corner_new;
      corner_new = cur;
    end

    if (emit) begin
      m = a;
      if (b > m) m = b;
      if (c > m) m = c;
      if (tri_total != '1) tri_total = tri_total + 1'b1;
      if (m > peak) peak = m;
      tri_item.pad            = '0;
      tri_item.vert_a         = {1'b0, base} + {1'b0, a};
      tri_item.vert_b         = {1'b0, base} + {1'b0, b};
      tri_item.vert_c         = {1'b0, base} + {1'b0, c};
      tri_item.triangle_count = tri_total;
      tri_item.max_index      = peak;
      tri_expected.insert(tri_expected.size(), tri_item);
    end

    if (is_last) clear_primitive();
  endtask

  always @(posedge clk) begin
    out_payload_t got, want;
    if (!rst_n) begin
      topo = MODE_LIST;
      base = '0;
      clear_primitive();
      tri_expected.delete();
    end else begin
      // Compare a delivered triangle with the oldest prediction
      if (out_tvalid && out_tready) begin
        got = out_payload_t'(out_tdata);
        if (tri_expected.size() == 0) begin
          note_mismatch("unexpected triangle", 64'(got.vert_a), 64'(0));
        end else begin
          want = tri_expected.pop_front();
          if (got.vert_a !== want.vert_a)
            note_mismatch("vert_a", 64'(got.vert_a), 64'(want.vert_a));
          if (got.vert_b !== want.vert_b)
            note_mismatch("vert_b", 64'(got.vert_b), 64'(want.vert_b));
          if (got.vert_c !== want.vert_c)
            note_mismatch("vert_c", 64'(got.vert_c), 64'(want.vert_c));
          if (got.triangle_count !== want.triangle_count)
            note_mismatch("triangle_count", 64'(got.triangle_count),
                          64'(want.triangle_count));
          if (got.max_index !== want.max_index)
            note_mismatch("max_index", 64'(got.max_index), 64'(want.max_index));
          if (got.pad !== want.pad)
            note_mismatch("pad", 64'(got.pad), 64'(want.pad));
        end
      end

      // Track register writes
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_MODE: topo = mode_t'(cfg_data[1:0]);
          CFG_BASE: base = cfg_data[BASE_WIDTH-1:0];
          default: ;
        endcase
      end

      if (in_tvalid && in_tready) assemble(in_tdata[INDEX_WIDTH-1:0], in_tlast);
    end
    fail_count <= mismatches;
    pending    <= tri_expected.size();
  end

endmodule

FILE: sim/tb.sv
// Testbench top for the triangle primitive assembly: stimulus, clock, reset and verdict.
module tb;
  import tpa_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 300;

  logic                      clk        = 1'b0;
  logic                      rst_n      = 1'b0;
  logic                      in_tvalid  = 1'b0;
  logic                      in_tready;
  logic [IN_WIDTH-1:0]       in_tdata   = '0;
  logic                      in_tlast   = 1'b0;
  logic                      out_tvalid;
  logic                      out_tready = 1'b0;
  logic [OUT_WIDTH-1:0]      out_tdata;
  logic                      cfg_valid  = 1'b0;
  logic                      cfg_ready;
  logic [CFG_IDX_WIDTH-1:0]  cfg_index  = '0;
  logic [CFG_DATA_WIDTH-1:0] cfg_data   = '0;

  int   fail_count;
  int   pending;
  int   cycle_count = 0;
  logic calm        = 1'b0;
  logic squeeze     = 1'b0;

  triangle_primitive_assembly dut (.*);

  tpa_checker chk (.*);

  always #1 clk = ~clk;

  // Give up on a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[triangle_primitive_assembly] ERROR");
      $finish;
    end
  end

  // Receiver: one long hold-off once squeeze is set, random stall bursts otherwise unless calm
  initial begin
    bit held;
    held = 1'b0;
    forever begin
      if (squeeze && !held) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        held = 1'b1;
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // Hold one index request until the block takes it
  task automatic push_index(input logic [IN_WIDTH-1:0] idx, input logic last, input int odds);
    if (!calm && odds != 0 && $urandom_range(0, odds) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= idx;
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
  endtask

  // Drop the input and wait until every predicted triangle has come out
  task automatic drain();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (3) @(posedge clk);
  endtask

  // Write both registers back to back, then release the channel
  task automatic set_config(input mode_t m, input logic [31:0] b);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_MODE;
    cfg_data  <= 32'(m);
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= CFG_BASE;
    cfg_data  <= b;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [31:0] pick_index();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 15);
      1: return 32'hFFFF_FFFF - $urandom_range(0, 15);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] pick_base();
    case ($urandom_range(0, 3))
      0: return 32'h0;
      1: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    mode_t m;
    int    sent, odds, prims, len;
    bit    cut;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // List with extreme indices, then a primitive too short for a triangle
    set_config(MODE_LIST, 32'h0);
    push_index(32'h0, 1'b0, 3);
    push_index(32'hFFFF_FFFF, 1'b0, 3);
    push_index(32'h5, 1'b0, 3);
    push_index(32'h3, 1'b0, 3);
    push_index(32'h4, 1'b0, 3);
    push_index(32'h9, 1'b1, 3);
    push_index(32'h7, 1'b1, 3);
    drain();

    // Fan with the largest base so the corners carry into bit 32
    set_config(MODE_FAN, 32'hFFFF_FFFF);
    push_index(32'd10, 1'b0, 3);
    push_index(32'd20, 1'b0, 3);
    push_index(32'hFFFF_FFFF, 1'b0, 3);
    push_index(32'd5, 1'b1, 3);
    drain();

    // Strip with alternating winding, left open across a switch to list
    set_config(MODE_STRIP, 32'h1);
    push_index(32'd1, 1'b0, 3);
    push_index(32'd2, 1'b0, 3);
    push_index(32'd3, 1'b0, 3);
    push_index(32'd4, 1'b0, 3);
    drain();
    set_config(MODE_LIST, 32'h1);
    push_index(32'd8, 1'b0, 3);
    push_index(32'd9, 1'b1, 3);
    drain();

    // Unsupported mode in the middle of a strip leaves its state alone
    set_config(MODE_STRIP, 32'h0);
    push_index(32'd11, 1'b0, 3);
    push_index(32'd12, 1'b0, 3);
    drain();
    set_config(MODE_NONE, 32'h0);
    push_index(32'd99, 1'b0, 3);
    drain();
    set_config(MODE_STRIP, 32'h0);
    push_index(32'd13, 1'b0, 3);
    push_index(32'd14, 1'b1, 3);
    drain();

    // Random segments of whole primitives, a few left open across a switch
    sent = 0;
    squeeze <= 1'b1;
    while (sent < 1800) begin
      calm = (sent > 1550);
      case ($urandom_range(0, 9))
        0, 1, 2: m = MODE_LIST;
        3, 4, 5: m = MODE_FAN;
        6, 7, 8: m = MODE_STRIP;
        default: m = MODE_NONE;
      endcase
      set_config(m, pick_base());
      odds  = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(2, 6);
      prims = $urandom_range(1, 4);
      for (int p = 0; p < prims; p++) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12);
        cut = (p == prims - 1) && ($urandom_range(0, 5) == 0);
        for (int k = 0; k < len; k++)
          push_index(pick_index(), (k == len - 1) && !cut, odds);
        sent += len;
      end
      drain();
    end

    if (fail_count == 0) begin
      $display("[triangle_primitive_assembly] OK");
    end else begin
      $display("[triangle_primitive_assembly] ERROR");
    end
    $finish;
  end

endmodule
